>>> hdl/hall_debounce_landmark_detector_top_assert.svh
// ----------------------------------------------------------------------------
// hall debounce landmark detector assertion macros
// same-cycle and next-cycle implication forms, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef HALL_DEBOUNCE_LANDMARK_DETECTOR_TOP_ASSERT_SVH
`define HALL_DEBOUNCE_LANDMARK_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define HDLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define HDLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HDLD_ASSERT_NOW(label, ante, cons, msg)

`define HDLD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/hdld_pkg.sv
// ----------------------------------------------------------------------------
// hdld_pkg
// shared types, codes and the level load function of the landmark detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdld_pkg;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_INIT   = 2'd2;

   localparam logic CSR_BASELINE = 1'b0;
   localparam logic CSR_DEBOUNCE = 1'b1;

   localparam logic [7:0] BASELINE_RESET = 8'd8;
   localparam logic [7:0] DEBOUNCE_RESET = 8'd3;

   typedef struct packed {
      logic [7:0] baseline_samples;
      logic [7:0] debounce_samples;
   } cfg_type;

   typedef struct packed {
      logic        last_raw;
      logic        stable_level;
      logic        pending_level;
      logic [7:0]  pending_run;
      logic [31:0] pending_start_ms;
      logic        idle_level;
      logic        learn_level;
      logic [7:0]  learn_run;
      logic        learned;
      logic        mark_active;
      logic        event_flag;
      logic [15:0] mark_count;
      logic [31:0] mark_time_ms;
   } state_type;

   // state after reset or after a reinitialize command
   function automatic state_type load_level(input logic lv);
      state_type s;
      s.last_raw         = lv;
      s.stable_level     = lv;
      s.pending_level    = lv;
      s.pending_run      = 8'd0;
      s.pending_start_ms = 32'd0;
      s.idle_level       = lv;
      s.learn_level      = lv;
      s.learn_run        = 8'd1;
      s.learned          = 1'b0;
      s.mark_active      = 1'b0;
      s.event_flag       = 1'b0;
      s.mark_count       = 16'd0;
      s.mark_time_ms     = 32'd0;
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hdl/hdld_csr.sv
// ----------------------------------------------------------------------------
// hdld_csr
// threshold registers written through the plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdld_csr
   import hdld_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BASELINE: cfg_in.baseline_samples = csr_wdata;
            CSR_DEBOUNCE: cfg_in.debounce_samples = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_samples <= BASELINE_RESET;
         cfg_ff.debounce_samples <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/hdld_update.sv
// ----------------------------------------------------------------------------
// hdld_update
// next-state logic for one item: baseline learning, debounce, landmark edge
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdld_update
   import hdld_pkg::*;
(
   input  wire state_type   cur,
   input  wire cfg_type     cfg,
   input  wire logic [1:0]  mode,
   input  wire logic        lv,
   input  wire logic [31:0] now_ms,
   output state_type        nxt
);

   always_comb begin
      logic [7:0] learn_run_nx;
      logic [7:0] pend_run_nx;
      nxt          = cur;
      learn_run_nx = cur.learn_run;
      pend_run_nx  = cur.pending_run;
      case (mode)
         MODE_SAMPLE: begin
            nxt.last_raw = lv;
            if (!cur.learned) begin
               if (lv != cur.learn_level) begin
                  nxt.learn_level = lv;
                  learn_run_nx    = 8'd1;
               end else if (cur.learn_run < cfg.baseline_samples) begin
                  learn_run_nx = cur.learn_run + 8'd1;
               end
               nxt.learn_run = learn_run_nx;
               if (learn_run_nx >= cfg.baseline_samples) begin
                  nxt.idle_level    = lv;
                  nxt.stable_level  = lv;
                  nxt.pending_level = lv;
                  nxt.pending_run   = 8'd0;
                  nxt.learned       = 1'b1;
               end
            end else if (lv == cur.stable_level) begin
               nxt.pending_level = lv;
               nxt.pending_run   = 8'd0;
            end else if (lv != cur.pending_level) begin
               // first differing sample opens a candidate run
               nxt.pending_level    = lv;
               nxt.pending_run      = 8'd1;
               nxt.pending_start_ms = now_ms;
            end else begin
               if (cur.pending_run < cfg.debounce_samples) begin
                  pend_run_nx = cur.pending_run + 8'd1;
               end
               nxt.pending_run = pend_run_nx;
               if (pend_run_nx >= cfg.debounce_samples) begin
                  nxt.stable_level  = lv;
                  nxt.pending_level = lv;
                  nxt.pending_run   = 8'd0;
                  if (lv == cur.idle_level) begin
                     nxt.mark_active = 1'b0;
                  end else if (!cur.mark_active) begin
                     nxt.mark_active  = 1'b1;
                     nxt.mark_count   = cur.mark_count + 16'd1;
                     nxt.mark_time_ms = cur.pending_start_ms;
                     nxt.event_flag   = 1'b1;
                  end
               end
            end
         end
         MODE_CLEAR: begin
            nxt.event_flag = 1'b0;
         end
         MODE_INIT: begin
            nxt = load_level(lv);
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/hall_debounce_landmark_detector_top.sv
// ----------------------------------------------------------------------------
// hall_debounce_landmark_detector_top
// hall sensor debouncer with baseline learning and landmark counting
// ----------------------------------------------------------------------------
// usage:
//  - req channel carries one item per sample: mode, sensor_level and now_ms;
//    mode 0 processes a sample, 1 clears the pending event, 2 reloads the
//    block from sensor_level, 3 leaves everything as it is
//  - rsp channel returns one item per request with the updated status
//  - csr port writes baseline_samples (index 0) and debounce_samples
//    (index 1); write only while no item is in flight
//  - path: an accepted request passes through the input register, then the
//    state register that also holds the result
//  - throughput: one item per cycle while rsp_stall is low; the state update
//    is a single pass of compare and increment logic between those two registers
//  - when rsp_stall is high while rsp_valid is high, the result and the state
//    hold; the input register keeps one waiting item and req_stall rises once it is full
//  - reset returns thresholds to 8 and 3 and the state to level zero with
//    nothing learned and no item in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hall_debounce_landmark_detector_top_assert.svh"

module hall_debounce_landmark_detector_top
   import hdld_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic        req_sensor_level,
   input  wire logic [31:0] req_now_ms,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sampled_level,
   output logic             rsp_steady_level,
   output logic             rsp_idle_level,
   output logic             rsp_learn_done,
   output logic             rsp_mark_on,
   output logic             rsp_event_flag,
   output logic [15:0]      rsp_landmark_total,
   output logic [31:0]      rsp_landmark_time_ms,

   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type     cfg;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [1:0]  s1_mode_ff;
   logic        s1_level_ff;
   logic [31:0] s1_time_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   state_type   state_ff;
   state_type   state_in;
   state_type   state_upd;

   logic        res_load;
   logic        advance;
   logic        req_take;

   hdld_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   hdld_update u_update (
      .cur    (state_ff),
      .cfg    (cfg),
      .mode   (s1_mode_ff),
      .lv     (s1_level_ff),
      .now_ms (s1_time_ff),
      .nxt    (state_upd)
   );

   // the state register doubles as the result register
   assign res_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && res_load;
   assign req_stall = s1_valid_ff && !res_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = res_load ? s1_valid_ff : rsp_valid_ff;
      state_in     = advance ? state_upd : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= load_level(1'b0);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_mode;
         s1_level_ff <= req_sensor_level;
         s1_time_ff  <= req_now_ms;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sampled_level    = state_ff.last_raw;
   assign rsp_steady_level     = state_ff.stable_level;
   assign rsp_idle_level       = state_ff.idle_level;
   assign rsp_learn_done       = state_ff.learned;
   assign rsp_mark_on          = state_ff.mark_active;
   assign rsp_event_flag       = state_ff.event_flag;
   assign rsp_landmark_total   = state_ff.mark_count;
   assign rsp_landmark_time_ms = state_ff.mark_time_ms;

   `HDLD_ASSERT_NOW(a_mark_learned, state_ff.mark_active, state_ff.learned, "mark before learn")
   `HDLD_ASSERT_NEXT(a_state_hold, !advance, $stable(state_ff), "state moved while idle")
   `HDLD_ASSERT_NOW(a_evt_cnt, $rose(rsp_event_flag), !$stable(rsp_landmark_total), "bad event")

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives timestamped hall samples and commands into the landmark detector,
// predicts every status item and checks each field as it leaves the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import hdld_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD   = 60;

   typedef struct packed {
      logic        sampled;
      logic        debounced;
      logic        baseline;
      logic        ready;
      logic        active;
      logic        pending;
      logic [15:0] total;
      logic [31:0] stamp;
   } landmark_status_type;

   // tracks the detector state and holds the status items still to come
   class landmark_scoreboard;
      state_type           st;
      logic [7:0]          thr_base;
      logic [7:0]          thr_deb;
      landmark_status_type status_q[$];
      int                  errors;

      function new();
         thr_base = BASELINE_RESET;
         thr_deb  = DEBOUNCE_RESET;
         errors   = 0;
         restart(1'b0);
      endfunction

      function void write_reg(logic idx, logic [7:0] value);
         if (idx == CSR_BASELINE) thr_base = value;
         else thr_deb = value;
      endfunction

      function void restart(logic lv);
         st.last_raw         = lv;
         st.stable_level     = lv;
         st.pending_level    = lv;
         st.pending_run      = 8'd0;
         st.pending_start_ms = 32'd0;
         st.idle_level       = lv;
         st.learn_level      = lv;
         st.learn_run        = 8'd1;
         st.learned          = 1'b0;
         st.mark_active      = 1'b0;
         st.event_flag       = 1'b0;
         st.mark_count       = 16'd0;
         st.mark_time_ms     = 32'd0;
      endfunction

      function void take_sample(logic lv, logic [31:0] t);
         st.last_raw = lv;
         if (!st.learned) begin
            if (lv != st.learn_level) begin
               st.learn_level = lv;
               st.learn_run   = 8'd1;
            end else if (st.learn_run < thr_base) begin
               st.learn_run = st.learn_run + 8'd1;
            end
            if (st.learn_run >= thr_base) begin
               st.idle_level    = lv;
               st.stable_level  = lv;
               st.pending_level = lv;
               st.pending_run   = 8'd0;
               st.learned       = 1'b1;
            end
            return;
         end
         if (lv == st.stable_level) begin
            st.pending_level = lv;
            st.pending_run   = 8'd0;
            return;
         end
         // first differing sample only opens the candidate run
         if (lv != st.pending_level) begin
            st.pending_level    = lv;
            st.pending_run      = 8'd1;
            st.pending_start_ms = t;
            return;
         end
         if (st.pending_run < thr_deb) st.pending_run = st.pending_run + 8'd1;
         if (st.pending_run >= thr_deb) begin
            st.stable_level  = lv;
            st.pending_level = lv;
            st.pending_run   = 8'd0;
            if (lv == st.idle_level) begin
               st.mark_active = 1'b0;
            end else if (!st.mark_active) begin
               st.mark_active  = 1'b1;
               st.mark_count   = st.mark_count + 16'd1;
               st.mark_time_ms = st.pending_start_ms;
               st.event_flag   = 1'b1;
            end
         end
      endfunction

      function void note_request(logic [1:0] mode, logic raw, logic [31:0] now);
         landmark_status_type s;
         case (mode)
            MODE_SAMPLE: take_sample(raw, now);
            MODE_CLEAR:  st.event_flag = 1'b0;
            MODE_INIT:   restart(raw);
            default: ;
         endcase
         s.sampled   = st.last_raw;
         s.debounced = st.stable_level;
         s.baseline  = st.idle_level;
         s.ready     = st.learned;
         s.active    = st.mark_active;
         s.pending   = st.event_flag;
         s.total     = st.mark_count;
         s.stamp     = st.mark_time_ms;
         status_q.push_back(s);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(landmark_status_type got);
         landmark_status_type want;
         if (status_q.size() == 0) begin
            report($sformatf("status item with nothing outstanding: %h", got));
            return;
         end
         want = status_q.pop_front();
         if (got.sampled !== want.sampled)
            report($sformatf("sampled_level got %b exp %b", got.sampled, want.sampled));
         if (got.debounced !== want.debounced)
            report($sformatf("steady_level got %b exp %b", got.debounced, want.debounced));
         if (got.baseline !== want.baseline)
            report($sformatf("idle_level got %b exp %b", got.baseline, want.baseline));
         if (got.ready !== want.ready)
            report($sformatf("learn_done got %b exp %b", got.ready, want.ready));
         if (got.active !== want.active)
            report($sformatf("mark_on got %b exp %b", got.active, want.active));
         if (got.pending !== want.pending)
            report($sformatf("event_flag got %b exp %b", got.pending, want.pending));
         if (got.total !== want.total)
            report($sformatf("landmark_total got %h exp %h", got.total, want.total));
         if (got.stamp !== want.stamp)
            report($sformatf("landmark_time_ms got %h exp %h", got.stamp, want.stamp));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_SAMPLE;
   logic        req_sensor_level = 1'b0;
   logic [31:0] req_now_ms = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sampled_level;
   logic        rsp_steady_level;
   logic        rsp_idle_level;
   logic        rsp_learn_done;
   logic        rsp_mark_on;
   logic        rsp_event_flag;
   logic [15:0] rsp_landmark_total;
   logic [31:0] rsp_landmark_time_ms;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_BASELINE;
   logic [7:0]  csr_wdata = 8'd0;

   landmark_scoreboard sb = new();

   int          cycle_count = 0;
   int          items_sent = 0;
   logic [31:0] time_ms = 32'd0;
   bit          sender_steady = 1'b0;
   bit          receiver_steady = 1'b0;
   bit          hold_request = 1'b0;

   hall_debounce_landmark_detector_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_sensor_level     (req_sensor_level),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sampled_level    (rsp_sampled_level),
      .rsp_steady_level     (rsp_steady_level),
      .rsp_idle_level       (rsp_idle_level),
      .rsp_learn_done       (rsp_learn_done),
      .rsp_mark_on          (rsp_mark_on),
      .rsp_event_flag       (rsp_event_flag),
      .rsp_landmark_total   (rsp_landmark_total),
      .rsp_landmark_time_ms (rsp_landmark_time_ms),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // both handshakes sampled on the rising edge, before the block updates
   always @(posedge clock) begin
      landmark_status_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_mode, req_sensor_level, req_now_ms);
         if (rsp_valid && !rsp_stall) begin
            got.sampled   = rsp_sampled_level;
            got.debounced = rsp_steady_level;
            got.baseline  = rsp_idle_level;
            got.ready     = rsp_learn_done;
            got.active    = rsp_mark_on;
            got.pending   = rsp_event_flag;
            got.total     = rsp_landmark_total;
            got.stamp     = rsp_landmark_time_ms;
            sb.check_result(got);
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] next_time();
      if ($urandom_range(0, 9) == 0) time_ms = $urandom;
      else time_ms = time_ms + $urandom_range(0, 100);
      return time_ms;
   endfunction

   // receiver side, long hold-off counted here when asked for
   initial begin
      int gap;
      int hold_count;
      wait (!reset);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            hold_count = 0;
            while (hold_count < LONG_HOLD) begin
               @(negedge clock);
               hold_count++;
            end
            hold_request = 1'b0;
         end else if (receiver_steady) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [1:0] mode, logic raw, logic [31:0] now);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_sensor_level <= raw;
      req_now_ms       <= now;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(logic level, int len);
      for (int i = 0; i < len; i++) begin
         // commands inside a run must not break it
         if ($urandom_range(0, 19) == 0)
            send_item($urandom_range(0, 1) ? MODE_CLEAR : MODE_UNUSED,
                      1'($urandom_range(0, 1)), $urandom);
         send_item(MODE_SAMPLE, level, next_time());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic set_thresholds(logic [7:0] base, logic [7:0] deb);
      wait_idle();
      write_csr(CSR_BASELINE, base);
      write_csr(CSR_DEBOUNCE, deb);
   endtask

   function automatic int pick_run_len();
      int r;
      int c;
      r = $urandom_range(0, 99);
      if (r < 45) c = int'(sb.thr_deb);
      else if (r < 65) c = int'(sb.thr_base);
      else return $urandom_range(1, 4);
      return $urandom_range((c > 1) ? c - 1 : 1, c + 2);
   endfunction

   task automatic random_phase(int count);
      int   first;
      int   r;
      int   len;
      logic level;
      first = items_sent;
      level = 1'($urandom_range(0, 1));
      send_item(MODE_INIT, level, $urandom);
      while (items_sent - first < count) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            // mostly alternate so runs do not merge
            if ($urandom_range(0, 4) != 0) level = ~level;
            // keep the phase close to its item budget
            len = pick_run_len();
            if (len > count - (items_sent - first)) len = count - (items_sent - first);
            send_run(level, len);
         end else if (r < 82) begin
            send_item(MODE_CLEAR, 1'($urandom_range(0, 1)), $urandom);
         end else if (r < 90) begin
            send_item(MODE_UNUSED, 1'($urandom_range(0, 1)), $urandom);
         end else if (r < 97) begin
            send_item(MODE_SAMPLE, 1'($urandom_range(0, 1)), next_time());
         end else begin
            level = 1'($urandom_range(0, 1));
            send_item(MODE_INIT, level, $urandom);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: learn a high baseline, then a low landmark
      send_item(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF);
      send_item(MODE_CLEAR, 1'b1, $urandom);
      time_ms = 32'd0;
      send_item(MODE_SAMPLE, 1'b1, 32'd0);
      send_run(1'b1, 7);
      send_item(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF);
      send_item(MODE_SAMPLE, 1'b0, 32'd5);
      send_item(MODE_SAMPLE, 1'b0, 32'd9);
      send_item(MODE_CLEAR, 1'b0, 32'hFFFF_FFFF);
      // a glitch back to the debounced level restarts the candidate run
      send_item(MODE_SAMPLE, 1'b1, 32'h8000_0000);
      send_item(MODE_SAMPLE, 1'b0, 32'h8000_0001);
      send_run(1'b1, 3);
      send_item(MODE_INIT, 1'b1, 32'hFFFF_FFFF);
      send_item(MODE_INIT, 1'b0, 32'd0);

      // zero thresholds: learned at once, a run accepted on its second sample
      set_thresholds(8'd0, 8'd0);
      send_item(MODE_SAMPLE, 1'b1, 32'h0000_0010);
      send_item(MODE_SAMPLE, 1'b0, 32'h7FFF_FFFF);
      send_item(MODE_SAMPLE, 1'b0, 32'h8000_0000);
      send_item(MODE_UNUSED, 1'b0, 32'd0);

      // receiver holds off while the sender keeps offering
      set_thresholds(8'd0, 8'd0);
      sender_steady = 1'b1;
      hold_request  = 1'b1;
      random_phase(60);
      sender_steady = 1'b0;

      set_thresholds(8'd1, 8'd1);
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      random_phase(60);
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;

      set_thresholds(8'($urandom_range(2, 12)), 8'($urandom_range(2, 6)));
      random_phase(110);

      set_thresholds(8'd255, 8'd255);
      random_phase(340);

      set_thresholds(8'd3, 8'd0);
      random_phase(60);

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.status_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
